/* rtl/iff_chunk_header_parser_top_defines.svh */
// Assertion helpers for the chunk header parser.
// Both forms sample on the block clock and are disabled while reset is low.
`ifndef IFF_CHUNK_HEADER_PARSER_TOP_DEFINES_SVH
`define IFF_CHUNK_HEADER_PARSER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFF_CHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFF_CHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iff_chp_pkg.sv */
`default_nettype none

package iff_chp_pkg;

    // Chunk header layout.
    localparam int HEADER_BYTES = 8;
    localparam int NAME_BYTES   = 4;
    localparam int PAD_MODULUS  = 2;

    // Field widths.
    localparam int BYTE_W     = 8;
    localparam int NAME_W     = 32;
    localparam int LEN_W      = 32;
    localparam int POS_W      = 33;
    localparam int HDR_CNT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_ORDER    = 2'd0,
        CFG_PAD_TO_EVEN   = 2'd1,
        CFG_BASE_OFFSET   = 2'd2,
        CFG_REGION_LENGTH = 2'd3
    } t_cfg_idx;

    // Current configuration as seen by the parser.
    typedef struct packed {
        logic              byte_order;
        logic              pad_to_even;
        logic [LEN_W-1:0]  base_offset;
        logic [LEN_W-1:0]  region_length;
    } t_cfg;

    // One parsed chunk descriptor.
    typedef struct packed {
        logic [NAME_W-1:0] chunk_name;
        logic [POS_W-1:0]  chunk_start;
        logic [LEN_W-1:0]  chunk_length;
    } t_result;

endpackage

`default_nettype wire

/* rtl/iff_chp_cfg.sv */
`default_nettype none

module iff_chp_cfg
    import iff_chp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register file; RIFF little-endian with padding after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_order    <= 1'b0;
            r_cfg.pad_to_even   <= 1'b1;
            r_cfg.base_offset   <= '0;
            r_cfg.region_length <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BYTE_ORDER:    r_cfg.byte_order    <= i_cfg_data[0];
                CFG_PAD_TO_EVEN:   r_cfg.pad_to_even   <= i_cfg_data[0];
                CFG_BASE_OFFSET:   r_cfg.base_offset   <= i_cfg_data[LEN_W-1:0];
                CFG_REGION_LENGTH: r_cfg.region_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/iff_chp_parse.sv */
`default_nettype none

module iff_chp_parse
    import iff_chp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_cfg                   i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_start_region,
    input  wire logic              i_room,
    output logic                   o_push,
    output t_result                o_result
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // Input word register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_start;

    // Parser state.
    t_phase               r_phase, n_phase, e_phase;
    logic [HDR_CNT_W-1:0] r_cnt, n_cnt, e_cnt;
    logic [NAME_W-1:0]    r_name, n_name;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_left, n_left, e_left;
    logic [LEN_W-1:0]     r_skip, n_skip, e_skip;
    logic [POS_W-1:0]     r_pos, n_pos, e_pos;

    logic              in_accept;
    logic              advance;
    logic              produce;
    logic [LEN_W-1:0]  len_next;
    logic [LEN_W-1:0]  rem;
    logic              pad;
    logic [LEN_W:0]    padded;
    logic [LEN_W+1:0]  diff;
    logic              padded_lt;
    logic [LEN_W-1:0]  clipped;

    // The held word is processed whenever the result queue has room.
    assign advance    = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        // A region start restarts parsing before the word itself is handled.
        e_phase = r_phase;
        e_cnt   = r_cnt;
        e_left  = r_left;
        e_skip  = r_skip;
        e_pos   = r_pos;
        if (r_start) begin
            e_phase = PH_HEADER;
            e_cnt   = '0;
            e_left  = i_cfg.region_length;
            e_skip  = '0;
            e_pos   = {1'b0, i_cfg.base_offset};
        end

        // Length assembly and clipping against the bytes left after the header.
        len_next  = i_cfg.byte_order ? {r_len[LEN_W-BYTE_W-1:0], r_byte}
                                     : {r_byte, r_len[LEN_W-1:BYTE_W]};
        rem       = e_left - LEN_W'(HEADER_BYTES);
        pad       = i_cfg.pad_to_even && ((len_next % LEN_W'(PAD_MODULUS)) != '0);
        padded    = {1'b0, len_next} + (LEN_W+1)'(pad);
        diff      = {2'b00, rem} - {1'b0, padded};
        padded_lt = !diff[LEN_W+1] && (diff != '0);
        clipped   = (len_next < rem) ? len_next : rem;

        n_phase = e_phase;
        n_cnt   = e_cnt;
        n_name  = r_name;
        n_len   = r_len;
        n_left  = e_left;
        n_skip  = e_skip;
        n_pos   = e_pos + POS_W'(1);
        produce = 1'b0;

        unique case (e_phase)
            PH_HEADER: begin
                if (e_cnt == '0 && e_left <= LEN_W'(HEADER_BYTES)) begin
                    n_phase = PH_DONE;
                end else begin
                    if (e_cnt < HDR_CNT_W'(NAME_BYTES)) begin
                        n_name = {r_name[NAME_W-BYTE_W-1:0], r_byte};
                    end else begin
                        n_len = len_next;
                    end
                    n_cnt = e_cnt + HDR_CNT_W'(1);
                    // Eighth header byte: emit the descriptor and set up the skip.
                    if (e_cnt == HDR_CNT_W'(HEADER_BYTES - 1)) begin
                        produce = 1'b1;
                        n_cnt   = '0;
                        n_left  = padded_lt ? diff[LEN_W-1:0] : '0;
                        if (padded != '0) begin
                            n_skip  = padded_lt ? padded[LEN_W-1:0] : rem;
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = (rem > LEN_W'(HEADER_BYTES)) ? PH_HEADER : PH_DONE;
                        end
                    end
                end
            end
            PH_SKIP: begin
                if (e_skip != '0) begin
                    n_skip = e_skip - LEN_W'(1);
                end
                if (e_skip <= LEN_W'(1)) begin
                    n_cnt   = '0;
                    n_phase = (e_left > LEN_W'(HEADER_BYTES)) ? PH_HEADER : PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // Input register and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HEADER;
            r_cnt      <= '0;
            r_name     <= '0;
            r_len      <= '0;
            r_left     <= '0;
            r_skip     <= '0;
            r_pos      <= '0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
            if (advance) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_name  <= n_name;
                r_len   <= n_len;
                r_left  <= n_left;
                r_skip  <= n_skip;
                r_pos   <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_byte  <= i_data_byte;
            r_start <= i_start_region;
        end
    end

    assign o_push                = advance && produce;
    assign o_result.chunk_name   = r_name;
    assign o_result.chunk_start  = n_pos;
    assign o_result.chunk_length = clipped;

endmodule

`default_nettype wire

/* rtl/iff_chp_outq.sv */
`default_nettype none

module iff_chp_outq
    import iff_chp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_result,
    output logic      o_room,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_result   o_result
);

    t_result     r_q [2];
    logic [1:0]  r_count;
    logic        pop;

    assign pop         = (r_count != 2'd0) && !i_out_stall;
    assign o_room      = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_result    = r_q[0];

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // Two-entry queue; entry zero is always the head word.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q[0] <= (r_count == 2'd2) ? r_q[1] : i_result;
            if (i_push && r_count == 2'd2) begin
                r_q[1] <= i_result;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_q[0] <= i_result;
            end else begin
                r_q[1] <= i_result;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/iff_chunk_header_parser_top.sv */
`default_nettype none

// RIFF/IFF chunk header parser. Region bytes come in one word per cycle on the input
// channel while it is not stalled; an accepted byte is held in the input register
// until the parser processes it. When the eighth byte of a chunk header is processed,
// a descriptor (name, absolute payload start, length clipped to the region) enters a
// two-entry output queue and is offered on the next cycle; the byte that completes
// the header thus passes the input register and then the queue before the result
// can be taken. The input stalls only while that queue is full and a byte waits in
// the input register. Configure byte order, padding, base offset and region length
// while the block is idle; base offset and region length are sampled when a word
// with start_region set is processed.

`include "iff_chunk_header_parser_top_defines.svh"

module iff_chunk_header_parser_top
    import iff_chp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [BYTE_W-1:0]     i_data_byte,
    input  wire logic                  i_start_region,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [NAME_W-1:0]          o_chunk_name,
    output logic [POS_W-1:0]           o_chunk_start,
    output logic [LEN_W-1:0]           o_chunk_length
);

    t_cfg    cfg;
    t_result push_result;
    t_result head_result;
    logic    push;
    logic    room;

    iff_chp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    iff_chp_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_start_region (i_start_region),
        .i_room         (room),
        .o_push         (push),
        .o_result       (push_result)
    );

    iff_chp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (push_result),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (head_result)
    );

    assign o_chunk_name   = head_result.chunk_name;
    assign o_chunk_start  = head_result.chunk_start;
    assign o_chunk_length = head_result.chunk_length;

    // The input side only stalls when both queue entries hold results.
    `IFF_CHP_ASSERT_SAME(a_stall_needs_result, o_in_stall, o_out_valid, "stall with empty queue")

    // The queue can only be full after the output side held off a word.
    `IFF_CHP_ASSERT_SAME(a_stall_after_out_stall, o_in_stall, $past(i_out_stall), "no out stall")

    // A waiting result that is not taken stays offered.
    `IFF_CHP_ASSERT_NEXT(a_result_held, o_out_valid && i_out_stall, o_out_valid, "result dropped")

endmodule

`default_nettype wire
